// ===== design/imu_sample_calibration_unit_macros.svh =====
// Assertion macros for the IMU sample calibration unit.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef IMU_SAMPLE_CALIBRATION_UNIT_MACROS_SVH
`define IMU_SAMPLE_CALIBRATION_UNIT_MACROS_SVH

// Implication checked on every rising clock edge, off during reset.
`define ISCU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the clock cycle after the antecedent.
`define ISCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/iscu_pkg.sv =====
// Shared types, constants and helpers for the IMU sample calibration unit.
// No dependencies.
package iscu_pkg;

  localparam int unsigned RawW    = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ModeW   = 5;
  localparam int unsigned RecipW  = 28;

  // Mode register fields
  localparam int unsigned ModeCalBit = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE         = 3'd0,
    CFG_GYRO_SCALE   = 3'd1,
    CFG_GYRO_OFFSETS = 3'd2,
    CFG_ACCEL_BIASES = 3'd3,
    CFG_MATRIX_X     = 3'd4,
    CFG_MATRIX_Y     = 3'd5,
    CFG_MATRIX_Z     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [RawW-1:0] raw_ax;
    logic signed [RawW-1:0] raw_ay;
    logic signed [RawW-1:0] raw_az;
    logic signed [RawW-1:0] raw_gx;
    logic signed [RawW-1:0] raw_gy;
    logic signed [RawW-1:0] raw_gz;
    logic                   read_failed;
  } in_word_t;

  typedef struct packed {
    logic                   status;
    logic signed [ValW-1:0] acc_x;
    logic signed [ValW-1:0] acc_y;
    logic signed [ValW-1:0] acc_z;
    logic signed [ValW-1:0] rate_x;
    logic signed [ValW-1:0] rate_y;
    logic signed [ValW-1:0] rate_z;
  } out_word_t;

  typedef struct packed {
    logic                   valid;
    logic [CfgIdxW-1:0]     index;
    logic [CfgW-1:0]        data;
  } cfg_wr_t;

  typedef struct packed {
    logic [ModeW-1:0]       mode;
    logic signed [ValW-1:0] gyro_scale;
    logic [CfgW-1:0]        gyro_offsets;
    logic [CfgW-1:0]        accel_biases;
    logic [2:0][CfgW-1:0]   matrix;       // row x at index 0
  } cfg_t;

  localparam logic [ModeW-1:0]       ModeReset  = 5'd10;
  localparam logic signed [ValW-1:0] ScaleReset = 32'sd65536;
  localparam logic [CfgW-1:0]        RowXReset  = 48'h0000_0000_4000;
  localparam logic [CfgW-1:0]        RowYReset  = 48'h0000_4000_0000;
  localparam logic [CfgW-1:0]        RowZReset  = 48'h4000_0000_0000;

  // Rounded 2^32 / sensitivity for the four gyro ranges
  function automatic logic [RecipW-1:0] gyro_recip(input logic [1:0] range);
    logic [RecipW-1:0] k;
    case (range)
      2'd0:    k = 28'd32786010;
      2'd1:    k = 28'd65572020;
      2'd2:    k = 28'd130944125;
      2'd3:    k = 28'd261888250;
      default: k = 28'd32786010;
    endcase
    return k;
  endfunction

endpackage

// ===== design/iscu_cfg_regs.sv =====
// Configuration register file for the IMU sample calibration unit.
// Depends on iscu_pkg.
module iscu_cfg_regs import iscu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t wr_i,
  output cfg_t    cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i.valid) begin
      case (cfg_idx_e'(wr_i.index))
        CFG_MODE:         cfg_d.mode         = wr_i.data[ModeW-1:0];
        CFG_GYRO_SCALE:   cfg_d.gyro_scale   = $signed(wr_i.data[ValW-1:0]);
        CFG_GYRO_OFFSETS: cfg_d.gyro_offsets = wr_i.data;
        CFG_ACCEL_BIASES: cfg_d.accel_biases = wr_i.data;
        CFG_MATRIX_X:     cfg_d.matrix[0]    = wr_i.data;
        CFG_MATRIX_Y:     cfg_d.matrix[1]    = wr_i.data;
        CFG_MATRIX_Z:     cfg_d.matrix[2]    = wr_i.data;
        default:          cfg_d = cfg_q;   // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= ModeReset;
      cfg_q.gyro_scale   <= ScaleReset;
      cfg_q.gyro_offsets <= '0;
      cfg_q.accel_biases <= '0;
      cfg_q.matrix[0]    <= RowXReset;
      cfg_q.matrix[1]    <= RowYReset;
      cfg_q.matrix[2]    <= RowZReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/imu_sample_calibration_unit.sv =====
// IMU sample calibration unit: four-stage pipeline, throughput one word per cycle while out_ready_i
// does not stall the output (the multiplies sit in stages 1 and 3).
// Each stage holds its word while the next one is full and stalled; bubbles close up.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the default
// configuration: mode 10, unity gyro scale, zero offsets and biases, identity matrix.
// Depends on iscu_pkg, iscu_cfg_regs and imu_sample_calibration_unit_macros.svh.
`include "imu_sample_calibration_unit_macros.svh"

module imu_sample_calibration_unit import iscu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t    cfg;
  cfg_wr_t cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  iscu_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_wr),
    .cfg_o  (cfg)
  );

  // Stage valids and per-stage advance
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  assign r4 = !v4_q || out_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // Stage 1: accel shift, gyro reciprocal multiply
  logic                      fail1_q;
  logic signed [20:0]        acc1_q [3];
  logic signed [20:0]        acc1_d [3];
  logic signed [44:0]        gp1_q  [3];
  logic signed [44:0]        gp1_d  [3];

  always_comb begin
    logic signed [RawW-1:0] ra [3];
    logic signed [RawW-1:0] rg [3];
    logic signed [RecipW:0] k_s;
    ra[0] = in_data_i.raw_ax;
    ra[1] = in_data_i.raw_ay;
    ra[2] = in_data_i.raw_az;
    rg[0] = in_data_i.raw_gx;
    rg[1] = in_data_i.raw_gy;
    rg[2] = in_data_i.raw_gz;
    k_s   = $signed({1'b0, gyro_recip(cfg.mode[3:2])});
    for (int k = 0; k < 3; k++) begin
      acc1_d[k] = 21'(ra[k]) <<< (3'(cfg.mode[1:0]) + 3'd2);
      gp1_d[k]  = 45'(rg[k]) * 45'(k_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      fail1_q <= in_data_i.read_failed;
      acc1_q  <= acc1_d;
      gp1_q   <= gp1_d;
    end
  end

  // Stage 2: round the rate, remove offset and bias
  logic               fail2_q;
  logic signed [20:0] acc2_q  [3];
  logic signed [28:0] rate2_q [3];
  logic signed [28:0] rate2_d [3];
  logic signed [29:0] d2_q    [3];
  logic signed [29:0] d2_d    [3];
  logic signed [21:0] t2_q    [3];
  logic signed [21:0] t2_d    [3];

  always_comb begin
    logic signed [44:0]     rnd;
    logic signed [RawW-1:0] off;
    logic signed [RawW-1:0] bias;
    for (int k = 0; k < 3; k++) begin
      rnd        = gp1_q[k] + 45'sd32768;
      rate2_d[k] = $signed(rnd[44:16]);
      off        = $signed(cfg.gyro_offsets[16*k +: 16]);
      bias       = $signed(cfg.accel_biases[16*k +: 16]);
      d2_d[k]    = 30'(rate2_d[k]) - (30'(off) <<< 8);
      t2_d[k]    = 22'(acc1_q[k]) - (22'(bias) <<< 4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      fail2_q <= fail1_q;
      acc2_q  <= acc1_q;
      rate2_q <= rate2_d;
      d2_q    <= d2_d;
      t2_q    <= t2_d;
    end
  end

  // Stage 3: gyro scale and matrix products
  logic               fail3_q;
  logic signed [20:0] acc3_q  [3];
  logic signed [28:0] rate3_q [3];
  logic signed [61:0] gs3_q   [3];
  logic signed [61:0] gs3_d   [3];
  logic signed [37:0] mp3_q   [3][3];
  logic signed [37:0] mp3_d   [3][3];

  always_comb begin
    logic signed [RawW-1:0] coef;
    for (int k = 0; k < 3; k++) begin
      gs3_d[k] = 62'(d2_q[k]) * 62'(cfg.gyro_scale);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef        = $signed(cfg.matrix[r][16*c +: 16]);
        mp3_d[r][c] = 38'(coef) * 38'(t2_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      fail3_q <= fail2_q;
      acc3_q  <= acc2_q;
      rate3_q <= rate2_q;
      gs3_q   <= gs3_d;
      mp3_q   <= mp3_d;
    end
  end

  // Stage 4: sum, round, saturate the rate, select, zero on a failed read
  function automatic logic signed [ValW-1:0] sat32(input logic signed [45:0] x);
    logic signed [ValW-1:0] y;
    if (x > 46'sd2147483647) begin
      y = 32'sh7fff_ffff;
    end else if (x < -46'sd2147483648) begin
      y = 32'sh8000_0000;
    end else begin
      y = 32'(x);
    end
    return y;
  endfunction

  out_word_t out_q;
  out_word_t out_d;

  always_comb begin
    logic signed [ValW-1:0] a [3];
    logic signed [ValW-1:0] g [3];
    logic signed [39:0]     sum;
    logic signed [25:0]     acal;
    logic signed [61:0]     grnd;
    logic signed [45:0]     gcal;
    logic                   cal;
    cal = cfg.mode[ModeCalBit];
    for (int k = 0; k < 3; k++) begin
      sum  = 40'(mp3_q[k][0]) + 40'(mp3_q[k][1]) + 40'(mp3_q[k][2]) + 40'sd8192;
      acal = $signed(sum[39:14]);
      grnd = gs3_q[k] + 62'sd32768;
      gcal = $signed(grnd[61:16]);
      a[k] = cal ? 32'(acal) : 32'(acc3_q[k]);
      g[k] = cal ? sat32(gcal) : 32'(rate3_q[k]);
      if (fail3_q) begin
        a[k] = '0;
        g[k] = '0;
      end
    end
    out_d.status = fail3_q;
    out_d.acc_x  = a[0];
    out_d.acc_y  = a[1];
    out_d.acc_z  = a[2];
    out_d.rate_x = g[0];
    out_d.rate_y = g[1];
    out_d.rate_z = g[2];
  end

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  `ISCU_ASSERT_IMP(a_ready_only_when_full, !in_ready_o,
    v1_q && v2_q && v3_q && v4_q && !out_ready_i, "input stalled with room in the pipeline")
  `ISCU_ASSERT_NEXT(a_stage3_holds, v3_q && !r4, v3_q, "stage 3 word lost during stall")
  `ISCU_ASSERT_IMP(a_fail_zero, out_valid_o && out_data_o.status,
    out_data_o.acc_x == 0 && out_data_o.acc_y == 0 && out_data_o.acc_z == 0 &&
    out_data_o.rate_x == 0 && out_data_o.rate_y == 0 && out_data_o.rate_z == 0,
    "failed read gave nonzero values")

endmodule
